>>> rtl/mcaas_pkg.sv
// Shared types and constants for the multichannel ADC average scaler.
package mcaas_pkg;

  // Default parameter values.
  localparam int unsigned CHANNELS_DEF    = 8;
  localparam int unsigned MAX_SAMPLES_DEF = 1024;
  localparam int unsigned SAMPLE_BITS_DEF = 16;

  // Fixed field widths.
  localparam int unsigned NUM_READINGS = 8;
  localparam int unsigned READING_W    = 16;
  localparam int unsigned CHANNEL_W    = 3;
  localparam int unsigned RESULT_W     = 16;
  localparam int unsigned COUNT_OUT_W  = 11;
  localparam int unsigned APB_ADDR_W   = 3;
  localparam int unsigned APB_DATA_W   = 32;

  // Register map (word index taken from paddr[2]).
  localparam logic REG_VREF = 1'b0;
  localparam logic [RESULT_W-1:0] VREF_RESET = 16'd3300;

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_FLUSH  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_START,
    ST_DIV,
    ST_PUT
  } seq_state_e;

  // Status of the shared divider seen by the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

>>> rtl/multichannel_adc_average_scaler_unit.sv
// Multichannel ADC accumulator with averaging and voltage scaling on flush.
// Latency: a sample transfer below the count limit updates the sums at the next edge; a
//   flush starts the divider, waits for its quotient and loads the output register, per channel in turn.
// Throughput: 1 sample item per cycle while idle; a flush holds the input until
//   the final channel result loads, each channel going through the shared bit-serial divider, plus
//   every cycle that a finished result waits on a stalled result side.
// Reset: sums and sample count clear, reference voltage returns to 3300.
module multichannel_adc_average_scaler_unit #(
  parameter int unsigned CHANNELS    = mcaas_pkg::CHANNELS_DEF,
  parameter int unsigned MAX_SAMPLES = mcaas_pkg::MAX_SAMPLES_DEF,
  parameter int unsigned SAMPLE_BITS = mcaas_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // APB configuration port
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [mcaas_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [mcaas_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [mcaas_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                 pready,
  // input channel
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic                                 op_i,
  input  logic [mcaas_pkg::READING_W-1:0]      reading_ch0_i,
  input  logic [mcaas_pkg::READING_W-1:0]      reading_ch1_i,
  input  logic [mcaas_pkg::READING_W-1:0]      reading_ch2_i,
  input  logic [mcaas_pkg::READING_W-1:0]      reading_ch3_i,
  input  logic [mcaas_pkg::READING_W-1:0]      reading_ch4_i,
  input  logic [mcaas_pkg::READING_W-1:0]      reading_ch5_i,
  input  logic [mcaas_pkg::READING_W-1:0]      reading_ch6_i,
  input  logic [mcaas_pkg::READING_W-1:0]      reading_ch7_i,
  // result channel
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [mcaas_pkg::CHANNEL_W-1:0]      channel_o,
  output logic [mcaas_pkg::RESULT_W-1:0]       average_o,
  output logic [mcaas_pkg::RESULT_W-1:0]       voltage_o,
  output logic [mcaas_pkg::COUNT_OUT_W-1:0]    sample_count_o,
  output logic                                 last_o
);
  import mcaas_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned SUM_W = SAMPLE_BITS + CNT_W;
  localparam int unsigned CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // Sequencer
  seq_state_e state_q, state_d;
  logic       in_xfer;
  logic       out_xfer;
  logic       slot_free;
  logic       div_start;
  logic       out_load;
  logic       acc_clear;
  logic       acc_add;
  logic       last_ch;

  // Datapath
  logic [SUM_W-1:0]        sum_q [CHANNELS];
  logic [CNT_W-1:0]        count_q;
  logic [CH_W-1:0]         ch_q;
  logic [RESULT_W-1:0]     vref_q;
  logic [READING_W-1:0]    rd [NUM_READINGS];
  div_status_t             div_st;
  logic [SAMPLE_BITS-1:0]  quotient;
  logic [RESULT_W-1:0]     avg16;
  logic [2*RESULT_W-1:0]   product;
  logic [31:0]             count_ext;
  logic [31:0]             ch_ext;
  logic                    full;

  logic                    out_valid_q;
  logic [CHANNEL_W-1:0]    channel_q;
  logic [RESULT_W-1:0]     average_q;
  logic [RESULT_W-1:0]     voltage_q;
  logic [COUNT_OUT_W-1:0]  sample_count_q;
  logic                    last_q;

  assign rd[0] = reading_ch0_i;
  assign rd[1] = reading_ch1_i;
  assign rd[2] = reading_ch2_i;
  assign rd[3] = reading_ch3_i;
  assign rd[4] = reading_ch4_i;
  assign rd[5] = reading_ch5_i;
  assign rd[6] = reading_ch6_i;
  assign rd[7] = reading_ch7_i;

  // Configuration: one register, always ready; byte offset bits are ignored.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_VREF) ? APB_DATA_W'(vref_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vref_q <= VREF_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_VREF)) begin
      vref_q <= pwdata[RESULT_W-1:0];
    end
  end

  // Handshakes: accept input only while idle; the output register frees
  // its slot when empty or when the current result transfers.
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_xfer   = out_valid_q && !out_stall_i;
  assign slot_free  = !out_valid_q || !out_stall_i;
  assign full       = (count_q == CNT_W'(MAX_SAMPLES));
  assign last_ch    = (ch_q == CH_W'(CHANNELS - 1));

  // Next-state logic
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer && (op_i == OP_FLUSH) && (count_q != '0)) begin
          state_d = ST_START;
        end
      end
      ST_START: begin
        state_d = ST_DIV;
      end
      ST_DIV: begin
        if (div_st.done) begin
          state_d = ST_PUT;
        end
      end
      ST_PUT: begin
        if (slot_free) begin
          state_d = last_ch ? ST_IDLE : ST_START;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control outputs of the sequencer
  always_comb begin
    div_start = 1'b0;
    out_load  = 1'b0;
    acc_clear = 1'b0;
    acc_add   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer && (op_i == OP_SAMPLE) && !full) begin
          acc_add = 1'b1;
        end
        // Flush with no samples only clears.
        if (in_xfer && (op_i == OP_FLUSH) && (count_q == '0)) begin
          acc_clear = 1'b1;
        end
      end
      ST_START: begin
        div_start = 1'b1;
      end
      ST_PUT: begin
        if (slot_free) begin
          out_load  = 1'b1;
          acc_clear = last_ch;
        end
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Accumulators: add every lane at once on a sample while the count is below MAX_SAMPLES.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        sum_q[i] <= '0;
      end
      count_q <= '0;
    end else if (acc_clear) begin
      for (int i = 0; i < CHANNELS; i++) begin
        sum_q[i] <= '0;
      end
      count_q <= '0;
    end else if (acc_add) begin
      for (int i = 0; i < CHANNELS; i++) begin
        sum_q[i] <= sum_q[i] + SUM_W'(rd[i][SAMPLE_BITS-1:0]);
      end
      count_q <= count_q + 1'b1;
    end
  end

  // Channel pointer: held at zero while idle, advance after each result load but the last.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ch_q <= '0;
    end else if (state_q == ST_IDLE) begin
      ch_q <= '0;
    end else if (out_load && !last_ch) begin
      ch_q <= ch_q + 1'b1;
    end
  end

  mcaas_div #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .CNT_W       (CNT_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_q[ch_q]),
    .divisor_i  (count_q),
    .status_o   (div_st),
    .quotient_o (quotient)
  );

  // Scale the held quotient straight into the output register.
  assign avg16     = RESULT_W'(quotient);
  assign product   = vref_q * avg16;
  assign count_ext = 32'(count_q);
  assign ch_ext    = 32'(ch_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_xfer) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      channel_q      <= ch_ext[CHANNEL_W-1:0];
      average_q      <= avg16;
      voltage_q      <= product[2*RESULT_W-1:RESULT_W];
      sample_count_q <= count_ext[COUNT_OUT_W-1:0];
      last_q         <= last_ch;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign channel_o      = channel_q;
  assign average_o      = average_q;
  assign voltage_o      = voltage_q;
  assign sample_count_o = sample_count_q;
  assign last_o         = last_q;

  // The divider must be idle whenever the sequencer starts it.
  a_div_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_st.busy)
    else $error("divider started while busy");

  // The sample count never passes its limit.
  a_count_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_SAMPLES))
    else $error("sample count beyond limit");

  // Loading the final channel result empties the accumulators.
  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && last_ch) |=> (count_q == '0) && (state_q == ST_IDLE))
    else $error("accumulators not cleared after final result");

  // Input stays stalled for the whole flush sequence.
  a_flush_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (div_st.busy || out_load) |-> in_stall_o)
    else $error("input accepted during flush");

endmodule

>>> rtl/mcaas_div.sv
// Shared restoring divider, one quotient bit per cycle.
module mcaas_div #(
  parameter int unsigned SAMPLE_BITS = 16,
  parameter int unsigned CNT_W       = 11
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [SAMPLE_BITS+CNT_W-1:0] dividend_i,
  input  logic [CNT_W-1:0]             divisor_i,
  output mcaas_pkg::div_status_t       status_o,
  output logic [SAMPLE_BITS-1:0]       quotient_o
);
  import mcaas_pkg::*;

  localparam int unsigned STEP_W = $clog2(SAMPLE_BITS + 1);

  logic                   busy_q, busy_d;
  logic [STEP_W-1:0]      step_q, step_d;
  logic [CNT_W-1:0]       rem_q, rem_d;
  logic [SAMPLE_BITS-1:0] quo_q, quo_d;
  logic [CNT_W-1:0]       dsr_q, dsr_d;
  logic [CNT_W:0]         shifted;
  logic [CNT_W:0]         trial;

  // The quotient is known to fit SAMPLE_BITS, so the upper dividend bits
  // start out as the partial remainder and stay below the divisor.
  always_comb begin
    shifted = {rem_q, quo_q[SAMPLE_BITS-1]};
    trial   = shifted - {1'b0, dsr_q};
    busy_d  = busy_q;
    step_d  = step_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    dsr_d   = dsr_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = STEP_W'(SAMPLE_BITS);
      rem_d  = dividend_i[SAMPLE_BITS+CNT_W-1:SAMPLE_BITS];
      quo_d  = dividend_i[SAMPLE_BITS-1:0];
      dsr_d  = divisor_i;
    end else if (busy_q && (step_q != '0)) begin
      step_d = step_q - 1'b1;
      if (shifted >= {1'b0, dsr_q}) begin
        rem_d = trial[CNT_W-1:0];
        quo_d = {quo_q[SAMPLE_BITS-2:0], 1'b1};
      end else begin
        rem_d = shifted[CNT_W-1:0];
        quo_d = {quo_q[SAMPLE_BITS-2:0], 1'b0};
      end
    end else if (busy_q) begin
      busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dsr_q <= dsr_d;
  end

  assign status_o.busy = busy_q;
  assign status_o.done = busy_q && (step_q == '0);
  assign quotient_o    = quo_q;

endmodule
